FILE: rtl/core/tlp_pkg.sv
// ----------------------------------------------------------------------------
// tlp_pkg
// Shared constants, types and status structs of the meter line parser.
// ----------------------------------------------------------------------------
package tlp_pkg;

    // Line buffer geometry
    localparam int LINE_BYTES = 32;
    localparam int MAX_ITEMS  = 32;
    localparam int ADDR_W     = $clog2(LINE_BYTES);
    localparam int CNT_W      = $clog2(LINE_BYTES + 1);
    localparam int CHAR_W     = 7;
    localparam int SUM_W      = 6;    // checksum is kept modulo 64
    localparam int MIN_LINE   = 7;    // shortest line worth checking, CR included
    localparam int ADPS_LEN   = 4;
    localparam int LAB_HEAD   = 5;    // label bytes looked at for overload events

    typedef logic [CHAR_W-1:0] t_char;
    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [CNT_W-1:0]  t_cnt;

    // Control characters
    localparam t_char CH_NUL = 7'h00;
    localparam t_char CH_STX = 7'h02;
    localparam t_char CH_ETX = 7'h03;
    localparam t_char CH_LF  = 7'h0A;
    localparam t_char CH_CR  = 7'h0D;
    localparam t_char CH_SP  = 7'h20;

    // Characters of the overload labels
    localparam t_char CH_A   = 7'h41;
    localparam t_char CH_D   = 7'h44;
    localparam t_char CH_P   = 7'h50;
    localparam t_char CH_S   = 7'h53;
    localparam t_char CH_I   = 7'h49;
    localparam t_char CH_R   = 7'h52;
    localparam t_char CH_0   = 7'h30;
    localparam t_char CH_1   = 7'h31;
    localparam t_char CH_3   = 7'h33;

    // Result item kinds
    localparam logic [1:0] KIND_LABEL = 2'd0;
    localparam logic [1:0] KIND_VALUE = 2'd1;
    localparam logic [1:0] KIND_FEND  = 2'd2;

    // Overload event codes
    localparam logic [2:0] EV_NONE = 3'd0;
    localparam logic [2:0] EV_ADPS = 3'd1;

    // Frame sync
    typedef enum logic [1:0] {
        SYNC_INIT,
        SYNC_WAIT_STX,
        SYNC_WAIT_ETX,
        SYNC_READY
    } t_sync;

    // Main sequencer
    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_SCAN_RD,
        SEQ_SCAN_USE,
        SEQ_DECIDE,
        SEQ_EMIT_RD,
        SEQ_EMIT_USE,
        SEQ_FEND
    } t_seq;

    // Token being scanned in a line
    typedef enum logic [1:0] {
        TOK_LABEL,
        TOK_VALUE,
        TOK_REST
    } t_tok;

    // Scan control into the line checker
    typedef struct packed {
        logic clr;
        logic en;
        t_cnt pos;
    } t_chk_ctl;

    // Line checker verdict and token geometry
    typedef struct packed {
        logic       pass;
        t_cnt       lab_len;
        t_cnt       val_at;
        t_cnt       val_len;
        logic [2:0] ev;
    } t_chk_res;

endpackage

FILE: rtl/core/teleinfo_line_parser_unit.sv
// ----------------------------------------------------------------------------
// teleinfo_line_parser_unit
// Frame sync, line buffering and line emission for meter serial bytes.
// ----------------------------------------------------------------------------
// An ordinary byte is taken while idle and written to the line RAM. A
// carriage return that closes a line of seven or more bytes starts a check:
// each stored byte is read back through the single RAM read port in a read
// state and a use state, a decide state settles the verdict, and a passing
// line then leaves one character per read and use state pair, held while the
// output is stalled. The input is stalled until the line is through. An ETX
// in ready waits in a frame-end state to place the frame-end item. The
// result register lets the next byte in while an earlier result still waits.
module teleinfo_line_parser_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_rx_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [1:0] o_item_kind,
    output logic [6:0] o_char_out,
    output logic       o_last_of_run,
    output logic [2:0] o_overload_event
);

    tlp_pkg::t_seq  r_state, n_state;
    tlp_pkg::t_sync r_sync,  n_sync;
    tlp_pkg::t_cnt  r_fill,  n_fill;
    tlp_pkg::t_cnt  r_len,   n_len;
    tlp_pkg::t_addr r_raddr, n_raddr;
    tlp_pkg::t_cnt  r_idx,   n_idx;

    logic           r_out_valid, n_out_valid;
    logic [1:0]     r_kind,      n_kind;
    tlp_pkg::t_char r_char,      n_char;
    logic           r_last,      n_last;
    logic [2:0]     r_oev,       n_oev;

    tlp_pkg::t_char    w_c;
    logic              w_in_xfer;
    logic              w_slot_free;
    logic              w_room;
    tlp_pkg::t_cnt     w_len_new;
    logic              w_last_pos;
    logic [tlp_pkg::CNT_W:0] w_tot;
    tlp_pkg::t_cnt     w_n;
    tlp_pkg::t_cnt     w_idx_nx;
    logic              w_is_last;
    logic              w_we;
    tlp_pkg::t_char    w_rdata;
    tlp_pkg::t_chk_ctl w_ctl;
    tlp_pkg::t_chk_res w_res;

    assign w_c         = i_rx_byte[tlp_pkg::CHAR_W-1:0];
    assign o_stall     = (r_state != tlp_pkg::SEQ_IDLE);
    assign w_in_xfer   = i_valid && !o_stall;
    assign w_slot_free = !r_out_valid || !i_stall;
    assign w_room      = (r_fill < tlp_pkg::t_cnt'(tlp_pkg::LINE_BYTES));
    assign w_len_new   = r_fill + tlp_pkg::t_cnt'(1);
    assign w_last_pos  = ((tlp_pkg::t_cnt'(r_raddr) + tlp_pkg::t_cnt'(1)) == r_len);

    // Run length, clipped to the item limit
    assign w_tot     = {1'b0, w_res.lab_len} + {1'b0, w_res.val_len};
    assign w_n       = (w_tot > tlp_pkg::MAX_ITEMS) ? tlp_pkg::t_cnt'(tlp_pkg::MAX_ITEMS)
                                                    : w_tot[tlp_pkg::CNT_W-1:0];
    assign w_idx_nx  = r_idx + tlp_pkg::t_cnt'(1);
    assign w_is_last = (w_idx_nx == w_n);

    // Line store
    tlp_ram #(
        .WIDTH (tlp_pkg::CHAR_W),
        .DEPTH (tlp_pkg::LINE_BYTES)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_fill[tlp_pkg::ADDR_W-1:0]),
        .i_wdata (w_c),
        .i_raddr (r_raddr),
        .o_rdata (w_rdata)
    );

    // Line checker
    tlp_line_chk u_line_chk (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_byte  (w_rdata),
        .o_res   (w_res)
    );

    // Frame sync next state
    always_comb begin
        n_sync = r_sync;
        if (w_in_xfer) begin
            case (w_c)
                tlp_pkg::CH_STX: begin
                    if (r_sync inside {tlp_pkg::SYNC_INIT, tlp_pkg::SYNC_WAIT_STX}) begin
                        n_sync = tlp_pkg::SYNC_WAIT_ETX;
                    end
                end
                tlp_pkg::CH_ETX: begin
                    if (r_sync == tlp_pkg::SYNC_WAIT_ETX) begin
                        n_sync = tlp_pkg::SYNC_READY;
                    end else if (r_sync == tlp_pkg::SYNC_INIT) begin
                        n_sync = tlp_pkg::SYNC_WAIT_STX;
                    end
                end
                default: ;
            endcase
        end
    end

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            tlp_pkg::SEQ_IDLE: begin
                if (w_in_xfer && (r_sync == tlp_pkg::SYNC_READY)) begin
                    if (w_c == tlp_pkg::CH_ETX) begin
                        n_state = tlp_pkg::SEQ_FEND;
                    end else if ((w_c == tlp_pkg::CH_CR) && w_room &&
                                 (w_len_new >= tlp_pkg::t_cnt'(tlp_pkg::MIN_LINE))) begin
                        n_state = tlp_pkg::SEQ_SCAN_RD;
                    end
                end
            end
            tlp_pkg::SEQ_SCAN_RD:  n_state = tlp_pkg::SEQ_SCAN_USE;
            tlp_pkg::SEQ_SCAN_USE: begin
                n_state = w_last_pos ? tlp_pkg::SEQ_DECIDE : tlp_pkg::SEQ_SCAN_RD;
            end
            tlp_pkg::SEQ_DECIDE: begin
                n_state = w_res.pass ? tlp_pkg::SEQ_EMIT_RD : tlp_pkg::SEQ_IDLE;
            end
            tlp_pkg::SEQ_EMIT_RD:  n_state = tlp_pkg::SEQ_EMIT_USE;
            tlp_pkg::SEQ_EMIT_USE: begin
                if (w_slot_free) begin
                    n_state = w_is_last ? tlp_pkg::SEQ_IDLE : tlp_pkg::SEQ_EMIT_RD;
                end
            end
            tlp_pkg::SEQ_FEND: begin
                if (w_slot_free) begin
                    n_state = tlp_pkg::SEQ_IDLE;
                end
            end
            default: n_state = tlp_pkg::SEQ_IDLE;
        endcase
    end

    // Sequencer outputs: buffer writes, scan control, emission
    always_comb begin
        n_fill      = r_fill;
        n_len       = r_len;
        n_raddr     = r_raddr;
        n_idx       = r_idx;
        n_out_valid = r_out_valid && i_stall;
        n_kind      = r_kind;
        n_char      = r_char;
        n_last      = r_last;
        n_oev       = r_oev;
        w_we        = 1'b0;
        w_ctl.clr   = 1'b0;
        w_ctl.en    = 1'b0;
        w_ctl.pos   = tlp_pkg::t_cnt'(r_raddr);

        case (r_state)
            tlp_pkg::SEQ_IDLE: begin
                if (w_in_xfer) begin
                    case (w_c)
                        tlp_pkg::CH_STX: n_fill = '0;
                        tlp_pkg::CH_ETX: ;
                        tlp_pkg::CH_LF:  ;
                        tlp_pkg::CH_CR: begin
                            if (r_sync == tlp_pkg::SYNC_READY) begin
                                w_we      = w_room;
                                n_len     = w_len_new;
                                n_fill    = '0;
                                n_raddr   = '0;
                                w_ctl.clr = 1'b1;
                            end
                        end
                        default: begin
                            if (r_sync == tlp_pkg::SYNC_READY) begin
                                if (w_room) begin
                                    w_we   = 1'b1;
                                    n_fill = w_len_new;
                                end else begin
                                    // overflow drops the whole line
                                    n_fill = '0;
                                end
                            end
                        end
                    endcase
                end
            end
            tlp_pkg::SEQ_SCAN_USE: begin
                w_ctl.en = 1'b1;
                n_raddr  = r_raddr + tlp_pkg::t_addr'(1);
            end
            tlp_pkg::SEQ_DECIDE: begin
                n_raddr = '0;
                n_idx   = '0;
            end
            tlp_pkg::SEQ_EMIT_USE: begin
                if (w_slot_free) begin
                    n_out_valid = 1'b1;
                    n_kind      = (r_idx < w_res.lab_len) ? tlp_pkg::KIND_LABEL
                                                          : tlp_pkg::KIND_VALUE;
                    n_char      = w_rdata;
                    n_last      = w_is_last;
                    n_oev       = w_is_last ? w_res.ev : tlp_pkg::EV_NONE;
                    n_idx       = w_idx_nx;
                    // jump from the label to the value once the label is out
                    if (w_idx_nx == w_res.lab_len) begin
                        n_raddr = w_res.val_at[tlp_pkg::ADDR_W-1:0];
                    end else begin
                        n_raddr = r_raddr + tlp_pkg::t_addr'(1);
                    end
                end
            end
            tlp_pkg::SEQ_FEND: begin
                if (w_slot_free) begin
                    n_out_valid = 1'b1;
                    n_kind      = tlp_pkg::KIND_FEND;
                    n_char      = tlp_pkg::CH_NUL;
                    n_last      = 1'b1;
                    n_oev       = tlp_pkg::EV_NONE;
                end
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tlp_pkg::SEQ_IDLE;
            r_sync      <= tlp_pkg::SYNC_INIT;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sync      <= n_sync;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
        end
    end

    // Working and result registers
    always_ff @(posedge i_clk) begin
        r_len   <= n_len;
        r_raddr <= n_raddr;
        r_idx   <= n_idx;
        r_kind  <= n_kind;
        r_char  <= n_char;
        r_last  <= n_last;
        r_oev   <= n_oev;
    end

    assign o_valid          = r_out_valid;
    assign o_item_kind      = r_kind;
    assign o_char_out       = r_char;
    assign o_last_of_run    = r_last;
    assign o_overload_event = r_oev;

endmodule

FILE: rtl/core/tlp_ram.sv
// ----------------------------------------------------------------------------
// tlp_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module tlp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/tlp_line_chk.sv
// ----------------------------------------------------------------------------
// tlp_line_chk
// Walks a buffered line one byte at a time: splits label, value and checksum
// character, accumulates the checksum and spots overload labels.
// ----------------------------------------------------------------------------
module tlp_line_chk (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tlp_pkg::t_chk_ctl i_ctl,
    input  tlp_pkg::t_char    i_byte,
    output tlp_pkg::t_chk_res o_res
);

    tlp_pkg::t_tok             r_tok,      n_tok;
    logic                      r_skip,     n_skip;
    logic                      r_chk_next, n_chk_next;
    logic                      r_have_chk, n_have_chk;
    logic                      r_zero,     n_zero;
    tlp_pkg::t_char            r_chk,      n_chk;
    logic [tlp_pkg::SUM_W-1:0] r_sum,      n_sum;
    tlp_pkg::t_cnt             r_lab_len,  n_lab_len;
    tlp_pkg::t_cnt             r_val_at,   n_val_at;
    tlp_pkg::t_cnt             r_val_len,  n_val_len;
    logic                      r_m_a,      n_m_a;
    logic                      r_m_ad,     n_m_ad;
    logic                      r_m_adp,    n_m_adp;
    logic                      r_m_adi,    n_m_adi;
    logic                      r_m_adps,   n_m_adps;
    logic                      r_m_adir,   n_m_adir;
    logic [2:0]                r_ev_dig,   n_ev_dig;

    logic           w_is_sep;
    logic           w_is_term;
    tlp_pkg::t_char w_dig;

    // A space right after a separator is data, not a separator
    assign w_is_sep  = (i_byte == tlp_pkg::CH_SP) && !r_skip;
    assign w_is_term = w_is_sep || (i_byte == tlp_pkg::CH_CR);
    assign w_dig     = i_byte - tlp_pkg::CH_0;

    // Per-byte scan update
    always_comb begin
        n_tok      = r_tok;
        n_skip     = r_skip;
        n_chk_next = r_chk_next;
        n_have_chk = r_have_chk;
        n_zero     = r_zero;
        n_chk      = r_chk;
        n_sum      = r_sum;
        n_lab_len  = r_lab_len;
        n_val_at   = r_val_at;
        n_val_len  = r_val_len;
        n_m_a      = r_m_a;
        n_m_ad     = r_m_ad;
        n_m_adp    = r_m_adp;
        n_m_adi    = r_m_adi;
        n_m_adps   = r_m_adps;
        n_m_adir   = r_m_adir;
        n_ev_dig   = r_ev_dig;

        if (i_ctl.clr) begin
            n_tok      = tlp_pkg::TOK_LABEL;
            n_skip     = 1'b0;
            n_chk_next = 1'b0;
            n_have_chk = 1'b0;
            n_zero     = 1'b0;
            n_chk      = tlp_pkg::CH_NUL;
            // the checksum sum starts from one space
            n_sum      = tlp_pkg::CH_SP[tlp_pkg::SUM_W-1:0];
            n_lab_len  = '0;
            n_val_at   = '0;
            n_val_len  = '0;
            n_m_a      = 1'b0;
            n_m_ad     = 1'b0;
            n_m_adp    = 1'b0;
            n_m_adi    = 1'b0;
            n_m_adps   = 1'b0;
            n_m_adir   = 1'b0;
            n_ev_dig   = tlp_pkg::EV_NONE;
        end else if (i_ctl.en) begin
            if (i_byte == tlp_pkg::CH_NUL) begin
                n_zero = 1'b1;
            end
            n_skip     = w_is_sep;
            n_chk_next = w_is_sep && (r_tok != tlp_pkg::TOK_LABEL);
            // byte after any later separator is the checksum character
            if (r_chk_next) begin
                n_chk      = i_byte;
                n_have_chk = 1'b1;
            end

            case (r_tok)
                tlp_pkg::TOK_LABEL: begin
                    if (w_is_sep) begin
                        n_tok    = tlp_pkg::TOK_VALUE;
                        n_val_at = i_ctl.pos + tlp_pkg::t_cnt'(1);
                    end else if (!w_is_term) begin
                        n_sum     = r_sum + i_byte[tlp_pkg::SUM_W-1:0];
                        n_lab_len = r_lab_len + tlp_pkg::t_cnt'(1);
                        // label head match, position equals label index here
                        case (i_ctl.pos)
                            tlp_pkg::t_cnt'(0): n_m_a = (i_byte == tlp_pkg::CH_A);
                            tlp_pkg::t_cnt'(1): n_m_ad = r_m_a && (i_byte == tlp_pkg::CH_D);
                            tlp_pkg::t_cnt'(2): begin
                                n_m_adp = r_m_ad && (i_byte == tlp_pkg::CH_P);
                                n_m_adi = r_m_ad && (i_byte == tlp_pkg::CH_I);
                            end
                            tlp_pkg::t_cnt'(3): begin
                                n_m_adps = r_m_adp && (i_byte == tlp_pkg::CH_S);
                                n_m_adir = r_m_adi && (i_byte == tlp_pkg::CH_R);
                            end
                            tlp_pkg::t_cnt'(tlp_pkg::LAB_HEAD - 1): begin
                                if (r_m_adir &&
                                    (i_byte inside {[tlp_pkg::CH_1:tlp_pkg::CH_3]})) begin
                                    n_ev_dig = w_dig[2:0] + 3'd1;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                tlp_pkg::TOK_VALUE: begin
                    if (w_is_term) begin
                        n_tok = tlp_pkg::TOK_REST;
                    end else begin
                        n_sum     = r_sum + i_byte[tlp_pkg::SUM_W-1:0];
                        n_val_len = r_val_len + tlp_pkg::t_cnt'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    // Control flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok      <= tlp_pkg::TOK_LABEL;
            r_skip     <= 1'b0;
            r_chk_next <= 1'b0;
            r_have_chk <= 1'b0;
            r_zero     <= 1'b0;
        end else begin
            r_tok      <= n_tok;
            r_skip     <= n_skip;
            r_chk_next <= n_chk_next;
            r_have_chk <= n_have_chk;
            r_zero     <= n_zero;
        end
    end

    // Accumulators and match flags
    always_ff @(posedge i_clk) begin
        r_chk     <= n_chk;
        r_sum     <= n_sum;
        r_lab_len <= n_lab_len;
        r_val_at  <= n_val_at;
        r_val_len <= n_val_len;
        r_m_a     <= n_m_a;
        r_m_ad    <= n_m_ad;
        r_m_adp   <= n_m_adp;
        r_m_adi   <= n_m_adi;
        r_m_adps  <= n_m_adps;
        r_m_adir  <= n_m_adir;
        r_ev_dig  <= n_ev_dig;
    end

    // Verdict
    always_comb begin
        o_res.pass = !r_zero && (r_tok != tlp_pkg::TOK_LABEL) && r_have_chk &&
                     (r_lab_len != '0) && (r_val_len != '0) &&
                     ((tlp_pkg::t_char'(r_sum) + tlp_pkg::CH_SP) == r_chk);
        o_res.lab_len = r_lab_len;
        o_res.val_at  = r_val_at;
        o_res.val_len = r_val_len;
        if ((r_lab_len == tlp_pkg::t_cnt'(tlp_pkg::ADPS_LEN)) && r_m_adps) begin
            o_res.ev = tlp_pkg::EV_ADPS;
        end else begin
            o_res.ev = r_ev_dig;
        end
    end

endmodule

FILE: rtl/core/tlp_checker.sv
// ----------------------------------------------------------------------------
// tlp_checker
// Port-level checks of the line parser, bound to the top level.
// ----------------------------------------------------------------------------
module tlp_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_stall,
    input logic [7:0] i_rx_byte,
    input logic       o_valid,
    input logic       i_stall,
    input logic [1:0] o_item_kind,
    input logic [6:0] o_char_out,
    input logic       o_last_of_run,
    input logic [2:0] o_overload_event
);

    // Nothing is offered right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result offered right after reset");

    // A stalled result is held unchanged
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_item_kind) && $stable(o_char_out) &&
                               $stable(o_last_of_run) && $stable(o_overload_event))
        else $error("stalled result changed");

    // Frame end is a bare closing item
    a_fend_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_item_kind == tlp_pkg::KIND_FEND) |->
            o_last_of_run && (o_char_out == '0) && (o_overload_event == tlp_pkg::EV_NONE))
        else $error("malformed frame-end item");

    // Overload events ride only on the closing item of a line run
    a_event_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_overload_event != tlp_pkg::EV_NONE) |->
            o_last_of_run && (o_item_kind != tlp_pkg::KIND_FEND))
        else $error("overload event off the closing line item");

    // The input closes only after a transferred ETX or carriage return
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_stall && !(i_valid && ((i_rx_byte[6:0] == tlp_pkg::CH_ETX) ||
                                  (i_rx_byte[6:0] == tlp_pkg::CH_CR))) |=> !o_stall)
        else $error("input stalled without a closing byte");

endmodule

bind teleinfo_line_parser_unit tlp_checker u_tlp_checker (.*);
